/* rtl/core/mdscr_pkg.sv */
`default_nettype none
package mdscr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_WIDTH = 32;
  localparam int NDIV = FRAC_BITS + 1;

  localparam logic [2:0] REG_MAX_GROWTH = 3'd0;
  localparam logic [2:0] REG_LIGHT_HALF = 3'd1;
  localparam logic [2:0] REG_CO2_HALF = 3'd2;
  localparam logic [2:0] REG_INV_YIELD = 3'd3;
  localparam logic [2:0] REG_MAINT = 3'd4;
  localparam logic [2:0] REG_DECAY = 3'd5;
  localparam logic [2:0] REG_SUC_EXPORT = 3'd6;
  localparam logic [2:0] REG_MODE = 3'd7;

  localparam logic [30:0] ONE_Q = 31'(64'd1 << FRAC_BITS);
  localparam logic [15:0] K_0P2 = 16'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [15:0] K_0P1 = 16'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [15:0] K_0P727 = 16'(((64'd727 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [15:0] K_0P65 = 16'(((64'd65 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [22:0] K_DISS = 23'd4837851;
  localparam logic [53:0] DISS_HALF = 54'd1 << 39;

  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  typedef struct packed {
    logic [30:0] light_conc;
    logic [30:0] co2_conc;
    logic [30:0] gas_co2_conc;
    logic [30:0] biomass_density;
    logic        is_ghost;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] light_delta;
    logic signed [31:0] co2_delta;
    logic signed [31:0] o2_delta;
    logic signed [31:0] sucrose_delta;
    logic signed [31:0] net_growth;
    logic               growth_valid;
  } rates_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > SAT_HI) begin
      r = 32'h7fff_ffff;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/monod_dual_substrate_cell_rates_top.sv */
`default_nettype none
// Dual-substrate Monod rate unit. One grid cell is taken on every clock at which start is
// high (busy is always low), and its rates appear on rates, in order, with done high for
// one cycle. The latency is set by the two 17-stage restoring dividers that form the
// light and CO2 ratios, followed by ten multiply and output stages. The receiver cannot
// stall the unit. Configuration is written through cfg_we, cfg_index and cfg_data while
// no transfer is in flight.
module monod_dual_substrate_cell_rates_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire mdscr_pkg::cell_t  grid_cell,
  output logic                   done,
  output mdscr_pkg::rates_t      rates,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [30:0]       cfg_data
);
  import mdscr_pkg::*;

  logic [30:0] max_growth_rate, light_half_saturation, co2_half_saturation;
  logic [30:0] inverse_yield, maintenance_rate, decay_rate, sucrose_export;
  logic [2:0]  mode_bits;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_growth_rate <= '0;
      light_half_saturation <= ONE_Q;
      co2_half_saturation <= ONE_Q;
      inverse_yield <= ONE_Q;
      maintenance_rate <= '0;
      decay_rate <= '0;
      sucrose_export <= '0;
      mode_bits <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_GROWTH: max_growth_rate <= cfg_data;
        REG_LIGHT_HALF: light_half_saturation <= cfg_data;
        REG_CO2_HALF:   co2_half_saturation <= cfg_data;
        REG_INV_YIELD:  inverse_yield <= cfg_data;
        REG_MAINT:      maintenance_rate <= cfg_data;
        REG_DECAY:      decay_rate <= cfg_data;
        REG_SUC_EXPORT: sucrose_export <= cfg_data;
        REG_MODE:       mode_bits <= cfg_data[2:0];
        default:        mode_bits <= mode_bits;
      endcase
    end
  end

  // Divider pipeline: stage 0 is the input register.
  logic        dv     [0:NDIV];
  logic [31:0] rem_l  [0:NDIV];
  logic [31:0] den_l  [0:NDIV];
  logic [16:0] q_l    [0:NDIV];
  logic [31:0] rem_c  [0:NDIV];
  logic [31:0] den_c  [0:NDIV];
  logic [16:0] q_c    [0:NDIV];
  logic        x0_l   [0:NDIV];
  logic        x0_c   [0:NDIV];
  logic [30:0] co2_p  [0:NDIV];
  logic [30:0] gas_p  [0:NDIV];
  logic [30:0] dens_p [0:NDIV];
  logic        gh_p   [0:NDIV];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    rem_l[0] <= {2'b00, grid_cell.light_conc[30:1]};
    den_l[0] <= 32'(grid_cell.light_conc) + 32'(light_half_saturation);
    q_l[0] <= '0;
    x0_l[0] <= grid_cell.light_conc[0];
    rem_c[0] <= {2'b00, grid_cell.co2_conc[30:1]};
    den_c[0] <= 32'(grid_cell.co2_conc) + 32'(co2_half_saturation);
    q_c[0] <= '0;
    x0_c[0] <= grid_cell.co2_conc[0];
    co2_p[0] <= grid_cell.co2_conc;
    gas_p[0] <= grid_cell.gas_co2_conc;
    dens_p[0] <= grid_cell.biomass_density;
    gh_p[0] <= grid_cell.is_ghost;
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [32:0] sh_l, sh_c, df_l, df_c;
    logic        ge_l, ge_c;

    always_comb begin
      sh_l = {rem_l[j], (j == 0) ? x0_l[j] : 1'b0};
      sh_c = {rem_c[j], (j == 0) ? x0_c[j] : 1'b0};
      df_l = sh_l - {1'b0, den_l[j]};
      df_c = sh_c - {1'b0, den_c[j]};
      ge_l = sh_l >= {1'b0, den_l[j]};
      ge_c = sh_c >= {1'b0, den_c[j]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_l[j+1] <= ge_l ? df_l[31:0] : sh_l[31:0];
      rem_c[j+1] <= ge_c ? df_c[31:0] : sh_c[31:0];
      q_l[j+1] <= {q_l[j][15:0], ge_l};
      q_c[j+1] <= {q_c[j][15:0], ge_c};
      den_l[j+1] <= den_l[j];
      den_c[j+1] <= den_c[j];
      x0_l[j+1] <= x0_l[j];
      x0_c[j+1] <= x0_c[j];
      co2_p[j+1] <= co2_p[j];
      gas_p[j+1] <= gas_p[j];
      dens_p[j+1] <= dens_p[j];
      gh_p[j+1] <= gh_p[j];
    end
  end

  // Arithmetic stages A through I, then the output register.
  logic va, vb, vc, vd, ve, vf, vg, vh, vi;

  logic [16:0] rl_fin, rc_fin;
  logic [30:0] mag;
  logic [47:0] a_prod;
  logic [53:0] d_prod;
  logic [44:0] w_prod;
  logic [30:0] a_val, a_dens;
  logic [16:0] a_rc;
  logic        a_ghost, a_dneg;
  logic [13:0] a_diss;
  logic [28:0] a_w;

  always_comb begin
    rl_fin = (den_l[NDIV] == '0) ? '0 : q_l[NDIV];
    rc_fin = (den_c[NDIV] == '0) ? '0 : q_c[NDIV];
    mag = (co2_p[NDIV] > gas_p[NDIV]) ? co2_p[NDIV] - gas_p[NDIV]
                                      : gas_p[NDIV] - co2_p[NDIV];
    a_prod = 48'(max_growth_rate) * 48'(rl_fin);
    d_prod = 54'(mag) * 54'(K_DISS) + DISS_HALF;
    w_prod = 45'(K_0P1) * 45'(maintenance_rate);
  end

  always_ff @(posedge clk) begin
    a_val <= a_prod[46:16];
    a_rc <= rc_fin;
    a_dens <= dens_p[NDIV];
    a_ghost <= gh_p[NDIV];
    a_diss <= d_prod[53:40];
    a_dneg <= co2_p[NDIV] > gas_p[NDIV];
    a_w <= w_prod[44:16];
  end

  logic [47:0] b_prod;
  logic [59:0] o_prod;
  logic [30:0] b_g, b_dens;
  logic [43:0] b_o2;
  logic        b_ghost, b_dneg;
  logic [13:0] b_diss;

  always_comb begin
    b_prod = 48'(a_val) * 48'(a_rc);
    o_prod = 60'(a_w) * 60'(a_dens);
  end

  always_ff @(posedge clk) begin
    b_g <= b_prod[46:16];
    b_o2 <= o_prod[59:16];
    b_dens <= a_dens;
    b_ghost <= a_ghost;
    b_diss <= a_diss;
    b_dneg <= a_dneg;
  end

  logic [61:0] c_prod;
  logic [45:0] c_gs;
  logic [30:0] c_g, c_dens;
  logic [43:0] c_o2;
  logic        c_ghost, c_dneg;
  logic [13:0] c_diss;

  assign c_prod = 62'(b_g) * 62'(sucrose_export);

  always_ff @(posedge clk) begin
    c_gs <= c_prod[61:16];
    c_g <= b_g;
    c_o2 <= b_o2;
    c_dens <= b_dens;
    c_ghost <= b_ghost;
    c_diss <= b_diss;
    c_dneg <= b_dneg;
  end

  logic [59:0] t2_prod;
  logic [47:0] d_t3;
  logic [48:0] d_gt;
  logic [43:0] d_t2;
  logic [30:0] d_g, d_dens;
  logic [43:0] d_o2;
  logic        d_ghost, d_dneg;
  logic [13:0] d_diss;

  assign t2_prod = 60'(K_0P2) * 60'(c_gs);

  always_ff @(posedge clk) begin
    d_t3 <= {c_gs, 2'b00};
    d_gt <= 49'(c_g) + 49'({c_gs, 2'b00});
    d_t2 <= t2_prod[59:16];
    d_g <= c_g;
    d_o2 <= c_o2;
    d_dens <= c_dens;
    d_ghost <= c_ghost;
    d_diss <= c_diss;
    d_dneg <= c_dneg;
  end

  logic [61:0]        e_pul, e_pvl;
  logic [48:0]        e_puh;
  logic [47:0]        e_pvh;
  logic signed [46:0] e_net;
  logic [30:0]        e_dens;
  logic [43:0]        e_o2;
  logic               e_ghost, e_dneg;
  logic [13:0]        e_diss;

  always_ff @(posedge clk) begin
    e_pul <= 62'(inverse_yield) * 62'(d_gt[30:0]);
    e_puh <= 49'(inverse_yield) * 49'(d_gt[48:31]);
    e_pvl <= 62'(inverse_yield) * 62'(d_t3[30:0]);
    e_pvh <= 48'(inverse_yield) * 48'(d_t3[47:31]);
    e_net <= 47'(d_g) - 47'(d_t2) - 47'(decay_rate) - 47'(maintenance_rate);
    e_dens <= d_dens;
    e_o2 <= d_o2;
    e_ghost <= d_ghost;
    e_diss <= d_diss;
    e_dneg <= d_dneg;
  end

  localparam logic [64:0] CAP60 = 65'd1 << 60;

  logic [80:0] su, sv;
  logic [60:0] f_u1, f_v1;
  logic [31:0] f_net;
  logic [30:0] f_dens;
  logic [43:0] f_o2;
  logic        f_ghost, f_dneg;
  logic [13:0] f_diss;

  always_comb begin
    su = 81'(e_pul) + (81'(e_puh) << 31);
    sv = 81'(e_pvl) + (81'(e_pvh) << 31);
  end

  always_ff @(posedge clk) begin
    f_u1 <= (su[80:16] > CAP60) ? CAP60[60:0] : su[76:16];
    f_v1 <= (sv[80:16] > CAP60) ? CAP60[60:0] : sv[76:16];
    f_net <= sat32(50'(e_net));
    f_dens <= e_dens;
    f_o2 <= e_o2;
    f_ghost <= e_ghost;
    f_diss <= e_diss;
    f_dneg <= e_dneg;
  end

  logic [61:0] g_qul, g_qvl;
  logic [60:0] g_quh, g_qvh;
  logic [31:0] g_net;
  logic [43:0] g_o2;
  logic        g_ghost, g_dneg;
  logic [13:0] g_diss;

  always_ff @(posedge clk) begin
    g_qul <= 62'(f_u1[30:0]) * 62'(f_dens);
    g_quh <= 61'(f_u1[60:31]) * 61'(f_dens);
    g_qvl <= 62'(f_v1[30:0]) * 62'(f_dens);
    g_qvh <= 61'(f_v1[60:31]) * 61'(f_dens);
    g_net <= f_net;
    g_o2 <= f_o2;
    g_ghost <= f_ghost;
    g_diss <= f_diss;
    g_dneg <= f_dneg;
  end

  localparam logic [75:0] CAP47 = 76'd1 << 47;

  logic [91:0] tu, tv;
  logic [47:0] h_u, h_v;
  logic [31:0] h_net;
  logic [43:0] h_o2;
  logic        h_ghost, h_dneg;
  logic [13:0] h_diss;

  always_comb begin
    tu = 92'(g_qul) + (92'(g_quh) << 31);
    tv = 92'(g_qvl) + (92'(g_qvh) << 31);
  end

  always_ff @(posedge clk) begin
    h_u <= (tu[91:16] > CAP47) ? CAP47[47:0] : tu[63:16];
    h_v <= (tv[91:16] > CAP47) ? CAP47[47:0] : tv[63:16];
    h_net <= g_net;
    h_o2 <= g_o2;
    h_ghost <= g_ghost;
    h_diss <= g_diss;
    h_dneg <= g_dneg;
  end

  logic [63:0] evo_prod, suc_prod;
  logic [47:0] i_evo, i_suc, i_u;
  logic [31:0] i_net;
  logic [43:0] i_o2;
  logic        i_ghost, i_dneg;
  logic [13:0] i_diss;

  always_comb begin
    evo_prod = 64'(K_0P727) * 64'(h_u);
    suc_prod = 64'(K_0P65) * 64'(h_v);
  end

  always_ff @(posedge clk) begin
    i_evo <= evo_prod[63:16];
    i_suc <= suc_prod[63:16];
    i_u <= h_u;
    i_net <= h_net;
    i_o2 <= h_o2;
    i_ghost <= h_ghost;
    i_diss <= h_diss;
    i_dneg <= h_dneg;
  end

  logic signed [49:0] j_ld, j_cd, j_od, j_sd, j_dterm;
  logic               react;

  always_comb begin
    j_ld = -$signed({2'b00, i_u});
    j_dterm = i_dneg ? -$signed({36'd0, i_diss}) : $signed({36'd0, i_diss});
    j_cd = mode_bits[2] ? j_ld + j_dterm : j_ld;
    j_od = $signed({2'b00, i_evo}) - $signed({6'd0, i_o2});
    j_sd = $signed({2'b00, i_suc});
    react = mode_bits[0] & ~i_ghost;
  end

  always_ff @(posedge clk) begin
    rates.light_delta <= react ? sat32(j_ld) : '0;
    rates.co2_delta <= react ? sat32(j_cd) : '0;
    rates.o2_delta <= react ? sat32(j_od) : '0;
    rates.sucrose_delta <= react ? sat32(j_sd) : '0;
    rates.net_growth <= mode_bits[1] ? i_net : '0;
    rates.growth_valid <= mode_bits[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
      done <= 1'b0;
    end else begin
      va <= dv[NDIV];
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
      vi <= vh;
      done <= vi;
    end
  end

endmodule
`default_nettype wire

/* dv/tb_monod_dual_substrate_cell_rates_top.sv */
module tb_monod_dual_substrate_cell_rates_top;
  import mdscr_pkg::*;

  localparam longint unsigned CAP60 = 64'd1 << 60;
  localparam int LATENCY = 28;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cell_t grid_cell;
  logic done;
  rates_t rates;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;

  monod_dual_substrate_cell_rates_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .grid_cell(grid_cell), .done(done),
    .rates(rates), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the rate registers.
  longint unsigned mu_max, k_light, k_co2, inv_yield, maint, decay, suc_exp;
  logic [2:0] mode;

  cell_t pending_cells[$];
  rates_t expected_rates[$];
  int mismatches;
  int cells_sent;
  int rates_seen;
  int idle_pct;

  function automatic longint unsigned mul_q(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >> FRAC_BITS;
    if (p > 128'(CAP60)) return CAP60;
    return p[63:0];
  endfunction

  function automatic longint unsigned monod_ratio(longint unsigned x, longint unsigned k);
    if (x + k == 0) return 0;
    return (x << FRAC_BITS) / (x + k);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic rates_t predict_rates(cell_t c);
    longint unsigned g, gs, t2, t3, u, suc, use_o2, evo, mag, r;
    longint ld, cd, od, sd, net;
    rates_t res;
    ld = 0; cd = 0; od = 0; sd = 0; net = 0;
    g = mul_q(mul_q(mu_max, monod_ratio(c.light_conc, k_light)),
              monod_ratio(c.co2_conc, k_co2));
    gs = mul_q(g, suc_exp);
    t3 = gs * 4;
    if (t3 > CAP60) t3 = CAP60;
    t2 = mul_q(K_0P2, gs);
    if (mode[0] && !c.is_ghost) begin
      r = g + t3;
      if (r > CAP60) r = CAP60;
      u = mul_q(mul_q(inv_yield, r), c.biomass_density);
      use_o2 = mul_q(mul_q(K_0P1, maint), c.biomass_density);
      evo = mul_q(K_0P727, u);
      suc = mul_q(K_0P65, mul_q(mul_q(inv_yield, t3), c.biomass_density));
      ld = -longint'(u);
      cd = -longint'(u);
      od = longint'(evo) - longint'(use_o2);
      sd = longint'(suc);
      if (mode[2]) begin
        mag = (c.co2_conc > c.gas_co2_conc) ? c.co2_conc - c.gas_co2_conc
                                            : c.gas_co2_conc - c.co2_conc;
        r = (mag * K_DISS + (64'd1 << 39)) >> 40;
        cd = (c.co2_conc > c.gas_co2_conc) ? cd - longint'(r) : cd + longint'(r);
      end
    end
    if (mode[1]) net = longint'(g) - longint'(t2) - longint'(decay) - longint'(maint);
    res.light_delta = clamp32(ld);
    res.co2_delta = clamp32(cd);
    res.o2_delta = clamp32(od);
    res.sucrose_delta = clamp32(sd);
    res.net_growth = clamp32(net);
    res.growth_valid = mode[1];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("rate mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_rates.push_back(predict_rates(grid_cell));
      cells_sent++;
      if (pending_cells.size() != 0 && $urandom_range(99) >= idle_pct) begin
        grid_cell <= pending_cells.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_cells.size() != 0 && $urandom_range(99) >= idle_pct) begin
      grid_cell <= pending_cells.pop_front();
      start <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst && done) begin
      rates_t want;
      if (expected_rates.size() == 0) begin
        $display("unexpected rate transfer");
        mismatches++;
      end else begin
        want = expected_rates.pop_front();
        rates_seen++;
        if (rates.light_delta !== want.light_delta)
          report_mismatch("light_delta", rates.light_delta, want.light_delta);
        if (rates.co2_delta !== want.co2_delta)
          report_mismatch("co2_delta", rates.co2_delta, want.co2_delta);
        if (rates.o2_delta !== want.o2_delta)
          report_mismatch("o2_delta", rates.o2_delta, want.o2_delta);
        if (rates.sucrose_delta !== want.sucrose_delta)
          report_mismatch("sucrose_delta", rates.sucrose_delta, want.sucrose_delta);
        if (rates.net_growth !== want.net_growth)
          report_mismatch("net_growth", rates.net_growth, want.net_growth);
        if (rates.growth_valid !== want.growth_valid)
          report_mismatch("growth_valid", 32'(rates.growth_valid), 32'(want.growth_valid));
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_GROWTH: mu_max = val;
      REG_LIGHT_HALF: k_light = val;
      REG_CO2_HALF: k_co2 = val;
      REG_INV_YIELD: inv_yield = val;
      REG_MAINT: maint = val;
      REG_DECAY: decay = val;
      REG_SUC_EXPORT: suc_exp = val;
      default: mode = val[2:0];
    endcase
  endtask

  task automatic drain();
    while (pending_cells.size() != 0 || start || expected_rates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [30:0] rand_value();
    case ($urandom_range(5))
      0: return 31'h7fff_ffff;
      1: return '0;
      2: return 31'($urandom_range(1 << 20));
      3: return 31'($urandom_range(1 << 18)) + 31'(ONE_Q);
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.light_conc = rand_value();
    c.co2_conc = rand_value();
    c.gas_co2_conc = rand_value();
    c.biomass_density = rand_value();
    c.is_ghost = ($urandom_range(9) == 0);
    return c;
  endfunction

  task automatic random_settings(bit extreme);
    write_reg(REG_MAX_GROWTH, extreme ? 31'h7fff_ffff : rand_value());
    write_reg(REG_LIGHT_HALF, extreme ? 31'h7fff_ffff : rand_value());
    write_reg(REG_CO2_HALF, extreme ? 31'd1 : rand_value());
    write_reg(REG_INV_YIELD, extreme ? 31'h7fff_ffff : rand_value());
    write_reg(REG_MAINT, extreme ? 31'h7fff_ffff : rand_value());
    write_reg(REG_DECAY, extreme ? 31'h7fff_ffff : rand_value());
    write_reg(REG_SUC_EXPORT, extreme ? 31'h7fff_ffff : rand_value());
    write_reg(REG_MODE, 31'($urandom_range(7)));
  endtask

  initial begin
    cell_t c;
    mismatches = 0;
    cells_sent = 0;
    rates_seen = 0;
    idle_pct = 0;
    start = 1'b0;
    grid_cell = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_GROWTH;
    cfg_data = '0;
    mu_max = 0; k_light = ONE_Q; k_co2 = ONE_Q; inv_yield = ONE_Q;
    maint = 0; decay = 0; suc_exp = 0; mode = 3'd3;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cells: zeros, full scale, ghosts, each mode.
    write_reg(REG_MAX_GROWTH, 31'(2 * ONE_Q));
    write_reg(REG_SUC_EXPORT, 31'(ONE_Q / 4));
    write_reg(REG_MAINT, 31'(ONE_Q / 8));
    write_reg(REG_DECAY, 31'(ONE_Q / 16));
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_MODE, 31'(m));
      c = '0; pending_cells.push_back(c);
      c = '1; pending_cells.push_back(c);
      c.is_ghost = 1'b0; c.gas_co2_conc = '0; pending_cells.push_back(c);
      drain();
    end
    write_reg(REG_LIGHT_HALF, '0);
    write_reg(REG_CO2_HALF, '0);
    c = '0; pending_cells.push_back(c);
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      random_settings(phase == 3 || phase == 11);
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 60;
        2: idle_pct = 0;
        default: idle_pct = 33;
      endcase
      for (int i = 0; i < 100; i++) pending_cells.push_back(rand_cell());
      drain();
    end

    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d cells and checked %0d rate transfers over 16 register settings.",
             cells_sent, rates_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* monod_dual_substrate_cell_rates_top.f */
rtl/core/mdscr_pkg.sv
rtl/core/monod_dual_substrate_cell_rates_top.sv
dv/tb_monod_dual_substrate_cell_rates_top.sv
